// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hdl/rqb_pkg.sv =====
package rqb_pkg;

	localparam logic [31:0] TAG_KEEP = 32'hFFFF_FFFC;
	localparam logic [31:0] QNAN_BIT = 32'h0040_0000;
	localparam logic [31:0] DEF_NAN  = 32'hFFC0_0000;
	localparam int          NUM_CHILD = 4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [2:0][31:0] vec3_t;

	typedef struct packed {
		vec3_t bmin;
		vec3_t bmax;
	} box_t;

	// Aligned sum, waiting for normalization and rounding.
	typedef struct packed {
		logic        spec;
		logic [31:0] spec_val;
		logic        sign;
		logic [7:0]  exp;
		logic [27:0] sum;
		logic        zero_sign;
	} add_mid_t;

	// Raw product, waiting for normalization and rounding.
	typedef struct packed {
		logic              spec;
		logic [31:0]       spec_val;
		logic              sign;
		logic signed [9:0] exp;
		logic [47:0]       prod;
	} mul_mid_t;

	function automatic logic is_nan(logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	endfunction

	function automatic logic fp_lt(logic [31:0] a, logic [31:0] b);
		logic r;
		if (is_nan(a) || is_nan(b)) begin
			r = 1'b0;
		end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
			r = 1'b0;
		end else if (a[31] != b[31]) begin
			r = a[31];
		end else if (!a[31]) begin
			r = a[30:0] < b[30:0];
		end else begin
			r = a[30:0] > b[30:0];
		end
		return r;
	endfunction

	// a - b, first half: pick the larger magnitude and align the other.
	function automatic add_mid_t fp_sub_align(logic [31:0] a, logic [31:0] b);
		add_mid_t    r;
		logic [31:0] nb;
		logic [31:0] x;
		logic [31:0] y;
		logic [7:0]  ex;
		logic [7:0]  ey;
		logic [23:0] mx;
		logic [23:0] my;
		logic [7:0]  d;
		logic [26:0] yx;
		logic [26:0] ys;
		logic [26:0] msk;
		logic        stk;
		nb = {~b[31], b[30:0]};
		r.spec = 1'b1;
		r.spec_val = 32'd0;
		if (is_nan(a)) begin
			r.spec_val = a | QNAN_BIT;
		end else if (is_nan(b)) begin
			r.spec_val = b | QNAN_BIT;
		end else if (is_inf(a) && is_inf(b)) begin
			r.spec_val = (a[31] == nb[31]) ? a : DEF_NAN;
		end else if (is_inf(a)) begin
			r.spec_val = a;
		end else if (is_inf(b)) begin
			r.spec_val = nb;
		end else begin
			r.spec = 1'b0;
		end
		r.zero_sign = (a[30:0] == 31'd0) && (nb[30:0] == 31'd0) && a[31] && nb[31];
		if (a[30:0] >= nb[30:0]) begin
			x = a;
			y = nb;
		end else begin
			x = nb;
			y = a;
		end
		ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		mx = {x[30:23] != 8'd0, x[22:0]};
		my = {y[30:23] != 8'd0, y[22:0]};
		d = ex - ey;
		yx = {my, 3'b000};
		if (d >= 8'd27) begin
			ys = 27'd0;
			stk = |my;
		end else begin
			msk = (27'd1 << d[4:0]) - 27'd1;
			ys = yx >> d[4:0];
			stk = |(yx & msk);
		end
		ys[0] = ys[0] | stk;
		if (x[31] ^ y[31]) begin
			r.sum = {1'b0, mx, 3'b000} - {1'b0, ys};
		end else begin
			r.sum = {1'b0, mx, 3'b000} + {1'b0, ys};
		end
		r.sign = x[31];
		r.exp = ex;
		return r;
	endfunction

	// a - b, second half: normalize and round to nearest even.
	function automatic logic [31:0] fp_sub_round(add_mid_t m);
		logic [26:0] n;
		logic [8:0]  e;
		logic [4:0]  lz;
		logic [4:0]  sh;
		logic [7:0]  enc;
		logic [30:0] mag;
		logic        up;
		logic [31:0] r;
		lz = 5'd0;
		for (int i = 0; i < 27; i++) begin
			if (m.sum[i]) lz = 5'(26 - i);
		end
		if (m.sum[27]) begin
			n = {m.sum[27:2], m.sum[1] | m.sum[0]};
			e = {1'b0, m.exp} + 9'd1;
		end else begin
			sh = ({4'd0, lz} < {1'b0, m.exp}) ? lz : 5'(m.exp - 8'd1);
			n = m.sum[26:0] << sh;
			e = {1'b0, m.exp} - {4'd0, sh};
		end
		enc = n[26] ? e[7:0] : 8'd0;
		up = n[2] & (n[1] | n[0] | n[3]);
		mag = {enc, n[25:3]} + {30'd0, up};
		if (m.spec) begin
			r = m.spec_val;
		end else if (m.sum == 28'd0) begin
			r = {m.zero_sign, 31'd0};
		end else if (e >= 9'd255) begin
			r = {m.sign, 8'hFF, 23'd0};
		end else begin
			r = {m.sign, mag};
		end
		return r;
	endfunction

	// a * b, first half: specials, exponent sum and mantissa product.
	function automatic mul_mid_t fp_mul_prod(logic [31:0] a, logic [31:0] b);
		mul_mid_t    r;
		logic [7:0]  ea;
		logic [7:0]  eb;
		logic [23:0] ma;
		logic [23:0] mb;
		logic        az;
		logic        bz;
		r.sign = a[31] ^ b[31];
		az = a[30:0] == 31'd0;
		bz = b[30:0] == 31'd0;
		r.spec = 1'b1;
		r.spec_val = 32'd0;
		if (is_nan(a)) begin
			r.spec_val = a | QNAN_BIT;
		end else if (is_nan(b)) begin
			r.spec_val = b | QNAN_BIT;
		end else if ((is_inf(a) && bz) || (az && is_inf(b))) begin
			r.spec_val = DEF_NAN;
		end else if (is_inf(a) || is_inf(b)) begin
			r.spec_val = {r.sign, 8'hFF, 23'd0};
		end else if (az || bz) begin
			r.spec_val = {r.sign, 31'd0};
		end else begin
			r.spec = 1'b0;
		end
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
		r.exp = $signed({2'b00, ea}) + $signed({2'b00, eb}) - 10'sd127;
		r.prod = ma * mb;
		return r;
	endfunction

	// a * b, second half: normalize, denormalize on underflow, round.
	function automatic logic [31:0] fp_mul_round(mul_mid_t m);
		logic [5:0]         lz;
		logic signed [10:0] big_e;
		logic [47:0]        mm;
		logic [47:0]        msk;
		logic [6:0]         rsh;
		logic               stk;
		logic [7:0]         enc;
		logic               up;
		logic [30:0]        mag;
		logic [31:0]        r;
		lz = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (m.prod[i]) lz = 6'(47 - i);
		end
		big_e = $signed({m.exp[9], m.exp}) + 11'sd1 - $signed({5'd0, lz});
		stk = 1'b0;
		enc = 8'd0;
		rsh = 7'(-m.exp);
		if (big_e >= 11'sd1) begin
			mm = m.prod << lz;
			enc = big_e[7:0];
		end else if (!m.exp[9]) begin
			mm = m.prod << m.exp[5:0];
		end else if (rsh >= 7'd48) begin
			mm = 48'd0;
			stk = |m.prod;
		end else begin
			msk = (48'd1 << rsh[5:0]) - 48'd1;
			mm = m.prod >> rsh[5:0];
			stk = |(m.prod & msk);
		end
		up = mm[23] & ((|mm[22:0]) | stk | mm[24]);
		mag = {enc, mm[46:24]} + {30'd0, up};
		if (m.spec) begin
			r = m.spec_val;
		end else if (big_e > 11'sd254) begin
			r = {m.sign, 8'hFF, 23'd0};
		end else begin
			r = {m.sign, mag};
		end
		return r;
	endfunction

endpackage

// ===== hdl/rqb_box_store.sv =====
module rqb_box_store (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [1:0]                        wr_child,
	input  rqb_pkg::vec3_t                    wr_min,
	input  rqb_pkg::vec3_t                    wr_max,
	output rqb_pkg::box_t [rqb_pkg::NUM_CHILD-1:0] boxes
);
	import rqb_pkg::*;

	box_t box_q [NUM_CHILD];

	// Load one child's corners; contents are undefined until written.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			box_q[wr_child] <= '{bmin: wr_min, bmax: wr_max};
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CHILD; c++) begin
			boxes[c] = box_q[c];
		end
	end
endmodule

// ===== hdl/rqb_slab_lane.sv =====
module rqb_slab_lane (
	input  logic                 clk,
	input  logic                 en,
	input  logic [1:0]           cidx,
	input  rqb_pkg::box_t        box,
	input  rqb_pkg::vec3_t       org,
	input  rqb_pkg::vec3_t       inv,
	input  logic [31:0]          t_far,
	input  logic [31:0]          t_near,
	output logic [31:0]          entry_s5,
	output logic                 hit_s5
);
	import rqb_pkg::*;

	add_mid_t [2:0] dmin_s1, dmax_s1;
	vec3_t          inv_s1, inv_s2;
	logic [31:0]    far_s1, far_s2, far_s3, far_s4;
	logic [31:0]    near_s1, near_s2, near_s3, near_s4;
	vec3_t          dmin_s2, dmax_s2;
	mul_mid_t [2:0] t1_s3, t2_s3;
	vec3_t          t1_s4, t2_s4;

	logic [31:0] ent, ext, lo12, hi12;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dmin_s1[k] <= fp_sub_align(box.bmin[k], org[k]);
				dmax_s1[k] <= fp_sub_align(box.bmax[k], org[k]);
				dmin_s2[k] <= fp_sub_round(dmin_s1[k]);
				dmax_s2[k] <= fp_sub_round(dmax_s1[k]);
				t1_s3[k]   <= fp_mul_prod(dmin_s2[k], inv_s2[k]);
				t2_s3[k]   <= fp_mul_prod(dmax_s2[k], inv_s2[k]);
				t1_s4[k]   <= fp_mul_round(t1_s3[k]);
				t2_s4[k]   <= fp_mul_round(t2_s3[k]);
			end
			inv_s1  <= inv;
			inv_s2  <= inv_s1;
			far_s1  <= t_far;
			far_s2  <= far_s1;
			far_s3  <= far_s2;
			far_s4  <= far_s3;
			near_s1 <= t_near;
			near_s2 <= near_s1;
			near_s3 <= near_s2;
			near_s4 <= near_s3;
			entry_s5 <= (ent & TAG_KEEP) | {30'd0, cidx};
			hit_s5   <= !fp_lt(ext, near_s4) && !is_nan(ext) && !is_nan(near_s4)
				&& fp_lt(ent, ext) && fp_lt(ent, far_s4);
		end
	end

	// Narrow the slab interval axis by axis.
	always_comb begin
		ent = fp_lt(t1_s4[0], t2_s4[0]) ? t1_s4[0] : t2_s4[0];
		ext = fp_lt(t2_s4[0], t1_s4[0]) ? t1_s4[0] : t2_s4[0];
		lo12 = 32'd0;
		hi12 = 32'd0;
		for (int k = 1; k < 3; k++) begin
			lo12 = fp_lt(t1_s4[k], t2_s4[k]) ? t1_s4[k] : t2_s4[k];
			hi12 = fp_lt(t2_s4[k], t1_s4[k]) ? t1_s4[k] : t2_s4[k];
			ent = fp_lt(lo12, ent) ? ent : lo12;
			ext = fp_lt(ext, hi12) ? ext : hi12;
		end
	end
endmodule

// ===== hdl/rqb_sort.sv =====
module rqb_sort (
	input  logic                   clk,
	input  logic                   en,
	input  logic [3:0][31:0]       ent_s5,
	input  logic [3:0]             mask_s5,
	output logic [3:0][31:0]       ent_s7,
	output logic [3:0]             mask_s7
);
	import rqb_pkg::*;

	logic [3:0][31:0] ent_s6;
	logic [3:0]       mask_s6;
	logic [3:0][31:0] l1, l2;

	function automatic logic [63:0] cas(logic [31:0] a, logic [31:0] b);
		return fp_lt(b, a) ? {b, a} : {a, b};
	endfunction

	always_comb begin
		{l1[0], l1[1]} = cas(ent_s5[0], ent_s5[1]);
		{l1[2], l1[3]} = cas(ent_s5[2], ent_s5[3]);
		{l2[0], l2[2]} = cas(ent_s6[0], ent_s6[2]);
		{l2[1], l2[3]} = cas(ent_s6[1], ent_s6[3]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ent_s6  <= l1;
			mask_s6 <= mask_s5;
			ent_s7[0] <= l2[0];
			ent_s7[3] <= l2[3];
			{ent_s7[1], ent_s7[2]} <= cas(l2[1], l2[2]);
			mask_s7 <= mask_s6;
		end
	end
endmodule

// ===== hdl/ray_quad_box_slab_test.sv =====
// Four-wide ray versus box slab test in single precision. A write word
// (op = 0) loads the min and max corners of one child box and returns
// nothing; a query word (op = 1) tests one ray against all four stored
// boxes and returns a hit mask and the four entry distances, tagged with
// the child index in the low two bits, in ascending order. One word is
// taken every cycle unless in_stall is high. A query passes seven
// register stages: two for the subtract (align, then normalize and
// round), two for the multiply (product, then normalize and round), one
// for the slab interval and hit test, and two for the sorting network.
// The first stage loads at the edge that takes the word. A stall on the
// output freezes the whole pipeline, so the input stalls only while a
// finished result waits at the output. A box written is seen by every
// query taken after it; boxes read before being written give undefined
// results.
module ray_quad_box_slab_test (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [1:0]  child_index,
	input  logic [31:0] vec_a_x,
	input  logic [31:0] vec_a_y,
	input  logic [31:0] vec_a_z,
	input  logic [31:0] vec_b_x,
	input  logic [31:0] vec_b_y,
	input  logic [31:0] vec_b_z,
	input  logic [31:0] t_far,
	input  logic [31:0] t_near,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  hit_bits,
	output logic [31:0] entry_sorted0,
	output logic [31:0] entry_sorted1,
	output logic [31:0] entry_sorted2,
	output logic [31:0] entry_sorted3
);
	import rqb_pkg::*;

	logic             adv;
	logic             acc;
	logic [7:1]       v_s;
	vec3_t            va, vb;
	box_t [NUM_CHILD-1:0] boxes;
	logic [3:0][31:0] ent_s5;
	logic [3:0]       hit_s5;
	logic [3:0][31:0] ent_s7;
	logic [3:0]       mask_s7;

	// Advance every stage unless a finished word is held at the output.
	assign adv      = !v_s[7] || !out_stall;
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	assign va = {vec_a_z, vec_a_y, vec_a_x};
	assign vb = {vec_b_z, vec_b_y, vec_b_x};

	// Valid bits ride alongside the data; only queries enter the pipe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[6:1], acc && (op == OP_QUERY)};
		end
	end

	rqb_box_store u_store (
		.clk      (clk),
		.wr_en    (acc && (op == OP_WRITE)),
		.wr_child (child_index),
		.wr_min   (va),
		.wr_max   (vb),
		.boxes    (boxes)
	);

	// One lane per child box, all fed the same ray.
	for (genvar c = 0; c < NUM_CHILD; c++) begin : g_lane
		rqb_slab_lane u_lane (
			.clk      (clk),
			.en       (adv),
			.cidx     (2'(c)),
			.box      (boxes[c]),
			.org      (va),
			.inv      (vb),
			.t_far    (t_far),
			.t_near   (t_near),
			.entry_s5 (ent_s5[c]),
			.hit_s5   (hit_s5[c])
		);
	end

	rqb_sort u_sort (
		.clk     (clk),
		.en      (adv),
		.ent_s5  (ent_s5),
		.mask_s5 (hit_s5),
		.ent_s7  (ent_s7),
		.mask_s7 (mask_s7)
	);

	assign out_valid     = v_s[7];
	assign hit_bits      = mask_s7;
	assign entry_sorted0 = ent_s7[0];
	assign entry_sorted1 = ent_s7[1];
	assign entry_sorted2 = ent_s7[2];
	assign entry_sorted3 = ent_s7[3];
endmodule

// ===== hdl/rqb_checker.sv =====
`include "assert_macros.svh"

module rqb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  hit_bits,
	input logic [31:0] entry_sorted0,
	input logic [31:0] entry_sorted1,
	input logic [31:0] entry_sorted2,
	input logic [31:0] entry_sorted3
);
	logic tags_ok;
	logic out_hold;

	// The network only swaps, so the four child tags stay a permutation.
	assign tags_ok = (entry_sorted0[1:0] != entry_sorted1[1:0])
		&& (entry_sorted0[1:0] != entry_sorted2[1:0])
		&& (entry_sorted0[1:0] != entry_sorted3[1:0])
		&& (entry_sorted1[1:0] != entry_sorted2[1:0])
		&& (entry_sorted1[1:0] != entry_sorted3[1:0])
		&& (entry_sorted2[1:0] != entry_sorted3[1:0]);

	assign out_hold = out_valid && out_stall;

	`ASSERT_CLK(a_tags_perm, !out_valid || tags_ok, "sorted tags are not a permutation")
	`ASSERT_CLK(a_stall_cause, !in_stall || out_hold, "input stalled needlessly")
	`ASSERT_NEXT(a_out_hold, out_hold, out_valid, "held result word dropped")
	`ASSERT_NEXT(a_out_stable, out_hold, $stable({hit_bits, entry_sorted0}), "held word changed")
endmodule

bind ray_quad_box_slab_test rqb_checker u_chk (.*);
